// ===== sv/quaternion_transform_accumulator_core_defines.svh =====
// Assertion helpers for the block's top-level RTL file.
`ifndef QUATERNION_TRANSFORM_ACCUMULATOR_CORE_DEFINES_SVH
`define QUATERNION_TRANSFORM_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define QTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qta: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define QTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qta: next-cycle check failed");

`endif

// ===== sv/qta_pkg.sv =====
`default_nettype none
package qta_pkg;

	localparam int IN_BITS  = 160;
	localparam int OUT_BITS = 384;
	localparam int PC_W     = 7;
	localparam int ITER_W   = 5;

	typedef logic [4:0] src_t;
	typedef logic [4:0] dest_t;
	typedef logic [3:0] kind_t;
	typedef logic [PC_W-1:0] pc_t;

	// Command codes
	localparam logic [1:0] CMD_IDENT  = 2'd0;
	localparam logic [1:0] CMD_ROTATE = 2'd1;
	localparam logic [1:0] CMD_SCALE  = 2'd2;
	localparam logic [1:0] CMD_TRANS  = 2'd3;

	// Micro-op kinds
	localparam kind_t K_NOP   = 4'd0;
	localparam kind_t K_MUL   = 4'd1;
	localparam kind_t K_CINIT = 4'd2;
	localparam kind_t K_CORD  = 4'd3;
	localparam kind_t K_CFIN  = 4'd4;
	localparam kind_t K_MAT   = 4'd5;
	localparam kind_t K_MATS  = 4'd6;
	localparam kind_t K_QCOM  = 4'd7;
	localparam kind_t K_IDENT = 4'd8;
	localparam kind_t K_TAIL  = 4'd9;
	localparam kind_t K_DONE  = 4'd10;

	// Multiplier operand sources
	localparam src_t S_Q0  = 5'd0;
	localparam src_t S_Q3  = 5'd3;
	localparam src_t S_SC  = 5'd4;
	localparam src_t S_R0  = 5'd5;
	localparam src_t S_R3  = 5'd8;
	localparam src_t S_S   = 5'd9;
	localparam src_t S_M0  = 5'd10;
	localparam src_t S_M8  = 5'd18;
	localparam src_t S_AX  = 5'd19;
	localparam src_t S_AZ  = 5'd21;
	localparam src_t S_FAC = 5'd22;
	localparam src_t S_V   = 5'd23;

	// Accumulator destinations
	localparam dest_t D_R1  = 5'd0;
	localparam dest_t D_R3  = 5'd2;
	localparam dest_t D_QN0 = 5'd3;
	localparam dest_t D_QN3 = 5'd6;
	localparam dest_t D_P0  = 5'd7;
	localparam dest_t D_P9  = 5'd16;
	localparam dest_t D_MO0 = 5'd17;
	localparam dest_t D_MO8 = 5'd25;
	localparam dest_t D_V   = 5'd26;
	localparam dest_t D_TR0 = 5'd27;
	localparam dest_t D_TR2 = 5'd29;
	localparam dest_t D_SC  = 5'd30;

	// Program entry points
	localparam pc_t PC_TAIL  = 7'd0;
	localparam pc_t PC_IDENT = 7'd22;
	localparam pc_t PC_SCALE = 7'd24;
	localparam pc_t PC_ROT   = 7'd26;
	localparam pc_t PC_TRANS = 7'd52;

	localparam logic [ITER_W-1:0] CORDIC_LAST = 5'd29;

	// Fixed-point constants
	localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
	localparam logic signed [47:0] ONE_Q16     = 48'sd65536;

	typedef struct packed {
		kind_t kind;
		src_t  a;
		src_t  b;
		logic  sh16;
		logic  neg;
		logic  first;
		logic  last;
		dest_t dest;
	} uop_t;

	typedef struct packed {
		logic              load;
		uop_t              uop;
		logic [ITER_W-1:0] iter;
		logic              deliver;
	} ctl_t;

	// atan(2^-i) in Q2.30
	function automatic logic signed [35:0] atan_q30(input logic [ITER_W-1:0] i);
		logic signed [35:0] v;
		case (i)
			5'd0: v = 36'sd843314857;
			5'd1: v = 36'sd497837829;
			5'd2: v = 36'sd263043837;
			5'd3: v = 36'sd133525159;
			5'd4: v = 36'sd67021687;
			5'd5: v = 36'sd33543516;
			5'd6: v = 36'sd16775851;
			5'd7: v = 36'sd8388437;
			5'd8: v = 36'sd4194283;
			5'd9: v = 36'sd2097149;
			default: v = 36'sd1 <<< (6'd30 - {1'b0, i});
		endcase
		return v;
	endfunction

	function automatic uop_t op_ctl(input kind_t k);
		uop_t u;
		u      = '0;
		u.kind = k;
		return u;
	endfunction

	function automatic uop_t op_mul(input src_t a, input src_t b, input logic sh16,
			input logic neg, input logic first, input logic last, input dest_t d);
		uop_t u;
		u.kind  = K_MUL;
		u.a     = a;
		u.b     = b;
		u.sh16  = sh16;
		u.neg   = neg;
		u.first = first;
		u.last  = last;
		u.dest  = d;
		return u;
	endfunction

	// Quaternion products ww, xx, yy, zz, xy, xz, yz, wx, wy, wz
	function automatic uop_t prod_op(input logic [3:0] k);
		src_t a;
		src_t b;
		case (k)
			4'd0: begin a = S_Q0;         b = S_Q0;         end
			4'd1: begin a = S_Q0 + 5'd1;  b = S_Q0 + 5'd1;  end
			4'd2: begin a = S_Q0 + 5'd2;  b = S_Q0 + 5'd2;  end
			4'd3: begin a = S_Q3;         b = S_Q3;         end
			4'd4: begin a = S_Q0 + 5'd1;  b = S_Q0 + 5'd2;  end
			4'd5: begin a = S_Q0 + 5'd1;  b = S_Q3;         end
			4'd6: begin a = S_Q0 + 5'd2;  b = S_Q3;         end
			4'd7: begin a = S_Q0;         b = S_Q0 + 5'd1;  end
			4'd8: begin a = S_Q0;         b = S_Q0 + 5'd2;  end
			default: begin a = S_Q0;      b = S_Q3;         end
		endcase
		return op_mul(a, b, 1'b0, 1'b0, 1'b1, 1'b1, D_P0 + dest_t'(k));
	endfunction

	// One row of the offset rotation, then the scaled add into translation
	function automatic uop_t tr_op(input logic [1:0] row, input logic [2:0] t);
		uop_t u;
		case (t)
			3'd0, 3'd1, 3'd2: u = op_mul(S_M0 + src_t'(row) * 5'd3 + src_t'(t),
					S_AX + src_t'(t), 1'b0, 1'b0, t == 3'd0, t == 3'd2, D_V);
			3'd4: u = op_mul(S_V, S_SC, 1'b1, 1'b0, 1'b1, 1'b1, D_TR0 + dest_t'(row));
			default: u = op_ctl(K_NOP);
		endcase
		return u;
	endfunction

	// Microprogram
	function automatic uop_t uop_rom(input pc_t pc);
		uop_t       u;
		logic [3:0] k;
		logic [1:0] g;
		logic [1:0] t;
		logic       ng;
		k = '0;
		g = '0;
		t = '0;
		ng = 1'b0;
		unique case (pc) inside
			[7'd0:7'd9]:   u = prod_op(4'(pc));
			7'd10:         u = op_ctl(K_NOP);
			7'd11:         u = op_ctl(K_MAT);
			[7'd12:7'd20]: begin
				k = 4'(pc - 7'd12);
				u = op_mul(S_M0 + src_t'(k), S_SC, 1'b0, 1'b0, 1'b1, 1'b1,
						D_MO0 + dest_t'(k));
			end
			7'd21: u = op_ctl(K_DONE);
			7'd22: u = op_ctl(K_IDENT);
			7'd23: u = op_ctl(K_TAIL);
			7'd24: u = op_mul(S_SC, S_FAC, 1'b1, 1'b0, 1'b1, 1'b1, D_SC);
			7'd25: u = op_ctl(K_TAIL);
			7'd26: u = op_ctl(K_CINIT);
			7'd27: u = op_ctl(K_CORD);
			7'd28: u = op_ctl(K_CFIN);
			7'd29: u = op_mul(S_S, S_AX, 1'b0, 1'b0, 1'b1, 1'b1, D_R1);
			7'd30: u = op_mul(S_S, S_AX + 5'd1, 1'b0, 1'b0, 1'b1, 1'b1, D_R1 + 5'd1);
			7'd31: u = op_mul(S_S, S_AZ, 1'b0, 1'b0, 1'b1, 1'b1, D_R3);
			7'd32: u = op_ctl(K_NOP);
			[7'd33:7'd48]: begin
				k = 4'(pc - 7'd33);
				g = k[3:2];
				t = k[1:0];
				case (g)
					2'd0: ng = (t != 2'd0);
					2'd1: ng = (t == 2'd3);
					2'd2: ng = (t == 2'd1);
					default: ng = (t == 2'd2);
				endcase
				u = op_mul(S_Q0 + src_t'(t), S_R0 + src_t'(g ^ t), 1'b0, ng,
						t == 2'd0, t == 2'd3, D_QN0 + dest_t'(g));
			end
			7'd49:         u = op_ctl(K_NOP);
			7'd50:         u = op_ctl(K_QCOM);
			7'd51:         u = op_ctl(K_TAIL);
			[7'd52:7'd61]: u = prod_op(4'(pc - 7'd52));
			7'd62:         u = op_ctl(K_NOP);
			7'd63:         u = op_ctl(K_MATS);
			[7'd64:7'd68]: u = tr_op(2'd0, 3'(pc - 7'd64));
			[7'd69:7'd73]: u = tr_op(2'd1, 3'(pc - 7'd69));
			[7'd74:7'd78]: u = tr_op(2'd2, 3'(pc - 7'd74));
			7'd79:         u = op_ctl(K_TAIL);
			default:       u = op_ctl(K_NOP);
		endcase
		return u;
	endfunction

	function automatic pc_t entry_pc(input logic [1:0] cmd);
		pc_t p;
		unique case (cmd)
			CMD_IDENT:  p = PC_IDENT;
			CMD_ROTATE: p = PC_ROT;
			CMD_SCALE:  p = PC_SCALE;
			default:    p = PC_TRANS;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== sv/qta_ctrl.sv =====
`default_nettype none
module qta_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [1:0]    cmd,
	output logic          m_tvalid,
	input  logic          m_tready,
	output qta_pkg::ctl_t ctl
);
	import qta_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]        state_q;
	pc_t               pc_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              accept;
	logic              deliver;
	uop_t              uop;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign deliver  = (state_q == ST_WAIT) && (!out_valid_q || m_tready);
	assign uop      = (state_q == ST_RUN) ? uop_rom(pc_q) : op_ctl(K_NOP);
	assign m_tvalid = out_valid_q;

	// Drive the datapath
	always_comb begin
		ctl.load    = accept;
		ctl.uop     = uop;
		ctl.iter    = iter_q;
		ctl.deliver = deliver;
	end

	// Sequence the microprogram
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= PC_TAIL;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						pc_q    <= entry_pc(cmd);
						iter_q  <= '0;
					end
				end
				ST_RUN: begin
					case (uop.kind)
						K_CORD: begin
							if (iter_q == CORDIC_LAST) begin
								iter_q <= '0;
								pc_q   <= pc_q + 1'b1;
							end else begin
								iter_q <= iter_q + 1'b1;
							end
						end
						K_TAIL: pc_q <= PC_TAIL;
						K_DONE: state_q <= ST_WAIT;
						default: pc_q <= pc_q + 1'b1;
					endcase
				end
				ST_WAIT: begin
					if (deliver) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== sv/qta_datapath.sv =====
`default_nettype none
module qta_datapath #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qta_pkg::ctl_t                 ctl,
	input  logic [qta_pkg::IN_BITS-1:0]   s_tdata,
	output logic [qta_pkg::OUT_BITS-1:0]  m_tdata
);
	import qta_pkg::*;

	localparam int SAT_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam logic signed [47:0] SAT_HI = (48'sd1 <<< (SAT_BITS - 1)) - 48'sd1;
	localparam logic signed [47:0] SAT_LO = -(48'sd1 <<< (SAT_BITS - 1));

	logic signed [31:0] q_q   [4];
	logic signed [31:0] qn_q  [4];
	logic signed [31:0] r_q   [4];
	logic signed [31:0] vec_q [3];
	logic signed [31:0] tr_q  [3];
	logic signed [31:0] m_q   [9];
	logic signed [31:0] mo_q  [9];
	logic signed [33:0] p_q   [10];
	logic signed [31:0] sc_q, s_q, v_q, angle_q, fac_q;
	logic signed [35:0] th_q, cx_q, cy_q;
	logic               neg_q;

	logic signed [63:0] mul_s1;
	logic               vld_s1, sh16_s1, neg_s1, first_s1, last_s1;
	dest_t              dest_s1;
	logic signed [47:0] acc_q;
	logic [OUT_BITS-1:0] out_q;

	logic signed [31:0] a_val, b_val;
	logic signed [63:0] prod;
	logic signed [63:0] rnd, shifted;
	logic signed [47:0] mr, sum, tr_sum;
	logic signed [31:0] res32, resn;
	logic [1:0]         tr_idx;
	logic signed [35:0] dx, dy, at, th2;
	logic signed [39:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
	logic signed [39:0] ent   [9];
	logic signed [39:0] ent_s [3];

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) return 32'sh7fffffff;
		if (v < -48'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] satn(input logic signed [47:0] v);
		if (v > SAT_HI) return SAT_HI[31:0];
		if (v < SAT_LO) return SAT_LO[31:0];
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] src_val(input src_t s);
		logic signed [31:0] v;
		unique case (s) inside
			[S_Q0:S_Q3]: v = q_q[2'(s - S_Q0)];
			S_SC:        v = sc_q;
			[S_R0:S_R3]: v = r_q[2'(s - S_R0)];
			S_S:         v = s_q;
			[S_M0:S_M8]: v = m_q[4'(s - S_M0)];
			[S_AX:S_AZ]: v = vec_q[2'(s - S_AX)];
			S_FAC:       v = fac_q;
			default:     v = v_q;
		endcase
		return v;
	endfunction

	// Select operands and multiply
	always_comb begin
		a_val = src_val(ctl.uop.a);
		b_val = src_val(ctl.uop.b);
		prod  = a_val * b_val;
	end

	// Round, shift and accumulate the registered product
	always_comb begin
		rnd     = mul_s1 + (sh16_s1 ? 64'sd32768 : 64'sd536870912);
		shifted = sh16_s1 ? (rnd >>> 16) : (rnd >>> 30);
		mr      = shifted[47:0];
		sum     = (first_s1 ? 48'sd0 : acc_q) + (neg_s1 ? -mr : mr);
		res32   = sat32(sum);
		resn    = satn(sum);
		tr_idx  = 2'(dest_s1 - D_TR0);
		tr_sum  = 48'(tr_q[tr_idx]) + 48'(resn);
	end

	// One CORDIC step
	always_comb begin
		dx  = cx_q >>> ctl.iter;
		dy  = cy_q >>> ctl.iter;
		at  = atan_q30(ctl.iter);
		th2 = 36'(angle_q) <<< 1;
	end

	// Rotation matrix from the stored products
	always_comb begin
		ww = 40'(p_q[0]);
		xx = 40'(p_q[1]);
		yy = 40'(p_q[2]);
		zz = 40'(p_q[3]);
		xy = 40'(p_q[4]);
		xz = 40'(p_q[5]);
		yz = 40'(p_q[6]);
		wx = 40'(p_q[7]);
		wy = 40'(p_q[8]);
		wz = 40'(p_q[9]);
		ent[0] = 40'(ONE_Q30) - ((yy + zz) <<< 1);
		ent[1] = (xy - wz) <<< 1;
		ent[2] = (xz + wy) <<< 1;
		ent[3] = (xy + wz) <<< 1;
		ent[4] = 40'(ONE_Q30) - ((xx + zz) <<< 1);
		ent[5] = (yz - wx) <<< 1;
		ent[6] = (xz - wy) <<< 1;
		ent[7] = (yz + wx) <<< 1;
		ent[8] = 40'(ONE_Q30) - ((xx + yy) <<< 1);
		ent_s[0] = ww + xx - yy - zz;
		ent_s[1] = ww - xx + yy - zz;
		ent_s[2] = ww - xx - yy + zz;
	end

	// Architectural state: quaternion, scale, translation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q[0] <= ONE_Q30[31:0];
			q_q[1] <= '0;
			q_q[2] <= '0;
			q_q[3] <= '0;
			sc_q   <= satn(ONE_Q16);
			for (int i = 0; i < 3; i++) tr_q[i] <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (ctl.uop.kind == K_MUL);
			if (ctl.uop.kind == K_IDENT) begin
				q_q[0] <= ONE_Q30[31:0];
				q_q[1] <= '0;
				q_q[2] <= '0;
				q_q[3] <= '0;
				sc_q   <= satn(ONE_Q16);
				for (int i = 0; i < 3; i++) tr_q[i] <= '0;
			end
			if (ctl.uop.kind == K_QCOM) begin
				for (int i = 0; i < 4; i++) q_q[i] <= qn_q[i];
			end
			if (vld_s1 && last_s1) begin
				if (dest_s1 == D_SC) sc_q <= resn;
				if (dest_s1 >= D_TR0 && dest_s1 <= D_TR2) tr_q[tr_idx] <= satn(tr_sum);
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			angle_q  <= s_tdata[31:0];
			vec_q[0] <= s_tdata[63:32];
			vec_q[1] <= s_tdata[95:64];
			vec_q[2] <= s_tdata[127:96];
			fac_q    <= s_tdata[159:128];
		end

		// advance the multiply stage
		mul_s1   <= prod;
		sh16_s1  <= ctl.uop.sh16;
		neg_s1   <= ctl.uop.neg;
		first_s1 <= ctl.uop.first;
		last_s1  <= ctl.uop.last;
		dest_s1  <= ctl.uop.dest;

		if (vld_s1) begin
			acc_q <= sum;
			if (last_s1) begin
				unique case (dest_s1) inside
					[D_R1:D_R3]:   r_q[2'(dest_s1 - D_R1 + 5'd1)] <= res32;
					[D_QN0:D_QN3]: qn_q[2'(dest_s1 - D_QN0)] <= res32;
					[D_P0:D_P9]:   p_q[4'(dest_s1 - D_P0)] <= sum[33:0];
					[D_MO0:D_MO8]: mo_q[4'(dest_s1 - D_MO0)] <= resn;
					D_V:           v_q <= resn;
					default:       ;
				endcase
			end
		end

		case (ctl.uop.kind)
			K_CINIT: begin
				cx_q <= GAIN_Q30;
				cy_q <= '0;
				if (th2 > HALF_PI_Q30) begin
					th_q  <= th2 - PI_Q30;
					neg_q <= 1'b1;
				end else if (th2 < -HALF_PI_Q30) begin
					th_q  <= th2 + PI_Q30;
					neg_q <= 1'b1;
				end else begin
					th_q  <= th2;
					neg_q <= 1'b0;
				end
			end
			K_CORD: begin
				if (!th_q[35]) begin
					cx_q <= cx_q - dy;
					cy_q <= cy_q + dx;
					th_q <= th_q - at;
				end else begin
					cx_q <= cx_q + dy;
					cy_q <= cy_q - dx;
					th_q <= th_q + at;
				end
			end
			K_CFIN: begin
				r_q[0] <= sat32(neg_q ? -48'(cx_q) : 48'(cx_q));
				s_q    <= sat32(neg_q ? -48'(cy_q) : 48'(cy_q));
			end
			K_MAT: begin
				for (int i = 0; i < 9; i++) m_q[i] <= sat32(48'(ent[i]));
			end
			K_MATS: begin
				for (int i = 0; i < 9; i++) m_q[i] <= sat32(48'(ent[i]));
				m_q[0] <= sat32(48'(ent_s[0]));
				m_q[4] <= sat32(48'(ent_s[1]));
				m_q[8] <= sat32(48'(ent_s[2]));
			end
			default: ;
		endcase

		// load the output word
		if (ctl.deliver) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) out_q[32*(4*r+c) +: 32] <= mo_q[3*r+c];
				out_q[32*(4*r+3) +: 32] <= tr_q[r];
			end
		end
	end

	assign m_tdata = out_q;

endmodule
`default_nettype wire

// ===== sv/quaternion_transform_accumulator_core.sv =====
// Quaternion transform accumulator: keeps a rotation quaternion (Q2.30), a uniform
// scale and a translation (Q16.16), applies one command per input word (identity,
// rotate, scale, translate) and returns the 3x4 scaled transform matrix as one
// output word. One command is worked at a time; s_tready is high only while the
// block is idle, and a new command may enter while the previous matrix still waits
// on the output register. The work is done by the single shared 32x32 multiplier,
// which runs every product of the microprogram one per cycle, and by the 30-step
// CORDIC loop that gives the half-angle sine and cosine.
`default_nettype none
`include "quaternion_transform_accumulator_core_defines.svh"
module quaternion_transform_accumulator_core #(
	parameter int WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// cmd[1:0]
	input  logic [1:0]                   s_tuser,
	// angle[31:0], vec_x[63:32], vec_y[95:64], vec_z[127:96], factor[159:128]
	input  logic [qta_pkg::IN_BITS-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23, 32 bits each
	output logic [qta_pkg::OUT_BITS-1:0] m_tdata
);
	import qta_pkg::*;

	ctl_t ctl;

	qta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl)
	);

	qta_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

	`QTA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`QTA_ASSERT_IMP(a_deliver_free, clk, arst_n, ctl.deliver, !m_tvalid || m_tready)
	`QTA_ASSERT_NXT(a_deliver_valid, clk, arst_n, ctl.deliver, m_tvalid)
	`QTA_ASSERT_IMP(a_work_when_busy, clk, arst_n, ctl.uop.kind != K_NOP, !s_tready)

endmodule
`default_nettype wire

// ===== verif/qta_checker.sv =====
`default_nettype none
module qta_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	input  wire                          s_tready,
	input  wire [1:0]                    s_tuser,
	input  wire [qta_pkg::IN_BITS-1:0]   s_tdata,
	input  wire                          m_tvalid,
	input  wire                          m_tready,
	input  wire [qta_pkg::OUT_BITS-1:0]  m_tdata,
	output int                           errors,
	output int                           pending,
	output int                           words_out
);
	timeunit 1ns;
	timeprecision 1ps;
	import qta_pkg::*;

	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint PI      = 64'sd3373259426;
	localparam longint GAIN    = 64'sd652032874;
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint Q16_ONE = 64'sd65536;

	longint atan_steps [30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
		32, 16, 8, 4, 2};

	// transform state as the block should hold it
	longint quat [4];
	longint scale_q16;
	longint trans [3];
	longint rmat [9];

	logic [OUT_BITS-1:0] expected_matrices [$];

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// rounded fixed-point product: add half an LSB, floor shift
	function automatic longint fx_mul(longint a, longint b, int sh);
		return (a * b + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint sfield(logic [31:0] f);
		return longint'($signed(f));
	endfunction

	function void build_rotation(bit sandwich);
		longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
		ww = fx_mul(quat[0], quat[0], 30); xx = fx_mul(quat[1], quat[1], 30);
		yy = fx_mul(quat[2], quat[2], 30); zz = fx_mul(quat[3], quat[3], 30);
		xy = fx_mul(quat[1], quat[2], 30); xz = fx_mul(quat[1], quat[3], 30);
		yz = fx_mul(quat[2], quat[3], 30); wx = fx_mul(quat[0], quat[1], 30);
		wy = fx_mul(quat[0], quat[2], 30); wz = fx_mul(quat[0], quat[3], 30);
		rmat[0] = sandwich ? ww + xx - yy - zz : Q30_ONE - 2 * (yy + zz);
		rmat[1] = 2 * (xy - wz);
		rmat[2] = 2 * (xz + wy);
		rmat[3] = 2 * (xy + wz);
		rmat[4] = sandwich ? ww - xx + yy - zz : Q30_ONE - 2 * (xx + zz);
		rmat[5] = 2 * (yz - wx);
		rmat[6] = 2 * (xz - wy);
		rmat[7] = 2 * (yz + wx);
		rmat[8] = sandwich ? ww - xx - yy + zz : Q30_ONE - 2 * (xx + yy);
		for (int i = 0; i < 9; i++) rmat[i] = clamp32(rmat[i]);
	endfunction

	function void reset_transform();
		quat = '{Q30_ONE, 0, 0, 0};
		scale_q16 = Q16_ONE;
		trans = '{0, 0, 0};
	endfunction

	function void rotate_by(longint ang, longint ax, longint ay, longint az);
		longint th, cx, cy, dx, dy, c, s;
		longint r [4];
		longint q [4];
		bit flip;
		th = 2 * ang; cx = GAIN; cy = 0; flip = 0;
		// fold the half angle into +-pi/2
		if (th > HALF_PI) begin
			th -= PI; flip = 1;
		end else if (th < -HALF_PI) begin
			th += PI; flip = 1;
		end
		for (int i = 0; i < 30; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (th >= 0) begin
				cx -= dx; cy += dy; th -= atan_steps[i];
			end else begin
				cx += dx; cy -= dy; th += atan_steps[i];
			end
		end
		c = clamp32(flip ? -cx : cx);
		s = clamp32(flip ? -cy : cy);
		r[0] = c;
		r[1] = clamp32(fx_mul(s, ax, 30));
		r[2] = clamp32(fx_mul(s, ay, 30));
		r[3] = clamp32(fx_mul(s, az, 30));
		q = quat;
		quat[0] = clamp32(fx_mul(q[0], r[0], 30) - fx_mul(q[1], r[1], 30)
			- fx_mul(q[2], r[2], 30) - fx_mul(q[3], r[3], 30));
		quat[1] = clamp32(fx_mul(q[0], r[1], 30) + fx_mul(q[1], r[0], 30)
			+ fx_mul(q[2], r[3], 30) - fx_mul(q[3], r[2], 30));
		quat[2] = clamp32(fx_mul(q[0], r[2], 30) - fx_mul(q[1], r[3], 30)
			+ fx_mul(q[2], r[0], 30) + fx_mul(q[3], r[1], 30));
		quat[3] = clamp32(fx_mul(q[0], r[3], 30) + fx_mul(q[1], r[2], 30)
			- fx_mul(q[2], r[1], 30) + fx_mul(q[3], r[0], 30));
	endfunction

	function void translate_by(longint ox, longint oy, longint oz);
		longint v;
		build_rotation(1'b1);
		for (int i = 0; i < 3; i++) begin
			v = fx_mul(rmat[3*i], ox, 30) + fx_mul(rmat[3*i+1], oy, 30)
				+ fx_mul(rmat[3*i+2], oz, 30);
			v = clamp32(v);
			v = clamp32(fx_mul(v, scale_q16, 16));
			trans[i] = clamp32(trans[i] + v);
		end
	endfunction

	// apply one command word and return the matrix it should produce
	function logic [OUT_BITS-1:0] apply_command(logic [1:0] c, logic [IN_BITS-1:0] w);
		logic [OUT_BITS-1:0] m;
		case (c)
			CMD_IDENT:  reset_transform();
			CMD_ROTATE: rotate_by(sfield(w[31:0]), sfield(w[63:32]), sfield(w[95:64]),
				sfield(w[127:96]));
			CMD_SCALE:  scale_q16 = clamp32(fx_mul(scale_q16, sfield(w[159:128]), 16));
			default:    translate_by(sfield(w[63:32]), sfield(w[95:64]), sfield(w[127:96]));
		endcase
		build_rotation(1'b0);
		for (int row = 0; row < 3; row++) begin
			for (int col = 0; col < 3; col++)
				m[32*(row*4+col) +: 32] = 32'(clamp32(fx_mul(rmat[row*3+col], scale_q16, 30)));
			m[32*(row*4+3) +: 32] = 32'(trans[row]);
		end
		return m;
	endfunction

	task automatic report(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	// predict on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		logic [OUT_BITS-1:0] want;
		if (!arst_n) begin
			reset_transform();
			expected_matrices.delete();
			errors = 0;
			words_out = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				words_out++;
				if (expected_matrices.size() == 0) begin
					report("output word with no command pending");
				end else begin
					want = expected_matrices.pop_front();
					for (int f = 0; f < 12; f++)
						if (m_tdata[32*f +: 32] !== want[32*f +: 32])
							report($sformatf("word %0d m%0d%0d got %h want %h", words_out,
								f / 4, f % 4, m_tdata[32*f +: 32], want[32*f +: 32]));
				end
			end
			if (s_tvalid && s_tready)
				expected_matrices.push_back(apply_command(s_tuser, s_tdata));
		end
		pending = expected_matrices.size();
	end
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import qta_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [1:0]          s_tuser;
	logic [IN_BITS-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_BITS-1:0] m_tdata;
	int                  errors;
	int                  pending;
	int                  words_out;
	int                  words_in;
	int                  idle_cycles;
	bit                  hold_req;
	int                  cmd_seen [4];

	localparam int IDLE_LIMIT = 5000;

	quaternion_transform_accumulator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	qta_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending), .words_out(words_out)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d words pending", pending);
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stall pattern, clean stretches, long hold-off on request
	initial begin
		int mode;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end
			mode = $urandom_range(0, 9);
			repeat ($urandom_range(5, 40)) begin
				if (hold_req) break;
				m_tready <= (mode < 3) ? 1'b1 : ($urandom_range(0, 99) < 20 * mode - 20);
				@(negedge clk);
			end
		end
	end

	// command in the low two bits, data fields above it
	function automatic logic [IN_BITS+1:0] pack_word(logic [1:0] cmd, logic [31:0] ang,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic [31:0] fac);
		return {fac, vz, vy, vx, ang, cmd};
	endfunction

	task automatic send(logic [IN_BITS+1:0] w);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= w[1:0];
		s_tdata  <= w[IN_BITS+1:2];
		do @(posedge clk); while (!s_tready);
		cmd_seen[w[1:0]]++;
		words_in++;
	endtask

	// drop valid for a random gap, sometimes none
	task automatic maybe_gap();
		if ($urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 30)) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] axis_val();
		case ($urandom_range(0, 5))
			0:       return 32'h4000_0000;
			1:       return 32'hC000_0000;
			2:       return 32'h0;
			3:       return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
		endcase
	endfunction

	function automatic logic [31:0] offset_val();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
	endfunction

	function automatic logic [31:0] factor_val();
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return 32'hFFFF_0000;
			default: return 32'(32'sd65536 + $signed($urandom_range(0, 16384)) - 32'sd8192);
		endcase
	endfunction

	function automatic logic [IN_BITS+1:0] random_word();
		logic [1:0] c;
		logic [31:0] ang;
		c = logic'($urandom_range(0, 1)) ? CMD_ROTATE : 2'($urandom_range(0, 3));
		if ($urandom_range(0, 19) == 0) c = CMD_IDENT;
		ang = ($urandom_range(0, 3) == 0) ? $urandom
			: 32'($signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000);
		case (c)
			CMD_ROTATE: return pack_word(c, ang, axis_val(), axis_val(), axis_val(), $urandom);
			CMD_SCALE:  return pack_word(c, $urandom, $urandom, $urandom, $urandom,
				factor_val());
			CMD_TRANS:  return pack_word(c, $urandom, offset_val(), offset_val(),
				offset_val(), $urandom);
			default:    return pack_word(c, $urandom, $urandom, $urandom, $urandom, $urandom);
		endcase
	endfunction

	initial begin
		logic [IN_BITS+1:0] dir [$];
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tuser    = '0;
		s_tdata    = '0;
		hold_req   = 0;
		words_in   = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identity, angle and axis extremes, folding, scale and offset extremes
		dir.push_back(pack_word(CMD_IDENT, '1, '1, '1, '1, '1));
		dir.push_back(pack_word(CMD_ROTATE, 32'h0, 32'h4000_0000, 0, 0, 0));
		dir.push_back(pack_word(CMD_ROTATE, 32'h1921_FB54, 0, 32'h4000_0000, 0, 0));
		dir.push_back(pack_word(CMD_ROTATE, 32'h3243_F6A9, 0, 0, 32'h4000_0000, 0));
		dir.push_back(pack_word(CMD_ROTATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 0));
		dir.push_back(pack_word(CMD_ROTATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 0));
		dir.push_back(pack_word(CMD_TRANS, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0));
		dir.push_back(pack_word(CMD_SCALE, 0, 0, 0, 0, 32'h7FFF_FFFF));
		dir.push_back(pack_word(CMD_SCALE, 0, 0, 0, 0, 32'h7FFF_FFFF));
		dir.push_back(pack_word(CMD_TRANS, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		dir.push_back(pack_word(CMD_SCALE, 0, 0, 0, 0, 32'h8000_0000));
		dir.push_back(pack_word(CMD_TRANS, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
		dir.push_back(pack_word(CMD_SCALE, 0, 0, 0, 0, 32'h0));
		dir.push_back(pack_word(CMD_IDENT, 0, 0, 0, 0, 0));
		dir.push_back(pack_word(CMD_ROTATE, 32'hE6DE_04AC, 32'h2D41_3CCD, 32'h2D41_3CCD, 0, 0));
		dir.push_back(pack_word(CMD_SCALE, 0, 0, 0, 0, 32'hFFFF_0000));
		dir.push_back(pack_word(CMD_TRANS, 0, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000, 0));
		dir.push_back(pack_word(CMD_IDENT, 0, 0, 0, 0, 0));
		foreach (dir[i]) send(dir[i]);

		// random part; receiver held off once while sending continues
		for (int n = 0; n < 950; n++) begin
			if (n == 200) hold_req = 1;
			if (n == 500) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				wait (pending == 0);
			end
			send(random_word());
			maybe_gap();
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("sent %0d command words (identity %0d, rotate %0d, scale %0d, translate %0d)",
			words_in, cmd_seen[CMD_IDENT], cmd_seen[CMD_ROTATE], cmd_seen[CMD_SCALE],
			cmd_seen[CMD_TRANS]);
		$display("checked %0d matrix words, %0d mismatches", words_out, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== quaternion_transform_accumulator_core.f =====
+incdir+sv
sv/qta_pkg.sv
sv/qta_ctrl.sv
sv/qta_datapath.sv
sv/quaternion_transform_accumulator_core.sv
verif/qta_checker.sv
verif/tb_top.sv
